@@ hdl/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/sip_pkg.sv @@
// ----------------------------------------------------------------------------
// sip_pkg
// Constants shared by the segment crossing pipeline.
// ----------------------------------------------------------------------------
package sip_pkg;

    // extra bit gained by a coordinate difference
    localparam int DIFF_GROW = 1;
    // register stages in the perp-dot front end
    localparam int PERP_LAT = 3;

endpackage

@@ hdl/sip_perp.sv @@
// ----------------------------------------------------------------------------
// sip_perp
// Three-stage front end: edge vectors, products, perp-dot differences.
// ----------------------------------------------------------------------------
module sip_perp #(
    parameter int COORD_BITS = 16
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_vld,
    input  logic signed [COORD_BITS-1:0]                       i_a_start_x,
    input  logic signed [COORD_BITS-1:0]                       i_a_start_z,
    input  logic signed [COORD_BITS-1:0]                       i_a_end_x,
    input  logic signed [COORD_BITS-1:0]                       i_a_end_z,
    input  logic signed [COORD_BITS-1:0]                       i_b_start_x,
    input  logic signed [COORD_BITS-1:0]                       i_b_start_z,
    input  logic signed [COORD_BITS-1:0]                       i_b_end_x,
    input  logic signed [COORD_BITS-1:0]                       i_b_end_z,
    output logic                                               o_vld,
    output logic signed [2*(COORD_BITS+sip_pkg::DIFF_GROW):0]  o_f,
    output logic signed [2*(COORD_BITS+sip_pkg::DIFF_GROW):0]  o_aa,
    output logic signed [2*(COORD_BITS+sip_pkg::DIFF_GROW):0]  o_bb,
    output logic signed [COORD_BITS+sip_pkg::DIFF_GROW-1:0]    o_bx,
    output logic signed [COORD_BITS+sip_pkg::DIFF_GROW-1:0]    o_bz,
    output logic signed [COORD_BITS-1:0]                       o_b1x,
    output logic signed [COORD_BITS-1:0]                       o_b1z
);
    import sip_pkg::*;

    localparam int W = COORD_BITS;
    localparam int D = W + DIFF_GROW;
    localparam int M = 2 * D;
    localparam int P = M + 1;

    logic [PERP_LAT-1:0] r_vld;

    logic signed [D-1:0] r_ax, r_az, r_bx, r_bz, r_cx, r_cz;
    logic signed [W-1:0] r_b1x, r_b1z;

    logic signed [M-1:0] r_p_azbx, r_p_axbz, r_p_azcx, r_p_axcz, r_p_bzcx, r_p_bxcz;
    logic signed [D-1:0] r_bx2, r_bz2;
    logic signed [W-1:0] r_b1x2, r_b1z2;

    logic signed [P-1:0] r_f, r_aa, r_bb;
    logic signed [D-1:0] r_bx3, r_bz3;
    logic signed [W-1:0] r_b1x3, r_b1z3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PERP_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        // edge vectors a, b and c = B2 - A2
        r_ax  <= {i_a_end_x[W-1], i_a_end_x} - {i_a_start_x[W-1], i_a_start_x};
        r_az  <= {i_a_end_z[W-1], i_a_end_z} - {i_a_start_z[W-1], i_a_start_z};
        r_bx  <= {i_b_end_x[W-1], i_b_end_x} - {i_b_start_x[W-1], i_b_start_x};
        r_bz  <= {i_b_end_z[W-1], i_b_end_z} - {i_b_start_z[W-1], i_b_start_z};
        r_cx  <= {i_b_end_x[W-1], i_b_end_x} - {i_a_end_x[W-1], i_a_end_x};
        r_cz  <= {i_b_end_z[W-1], i_b_end_z} - {i_a_end_z[W-1], i_a_end_z};
        r_b1x <= i_b_start_x;
        r_b1z <= i_b_start_z;

        r_p_azbx <= r_az * r_bx;
        r_p_axbz <= r_ax * r_bz;
        r_p_azcx <= r_az * r_cx;
        r_p_axcz <= r_ax * r_cz;
        r_p_bzcx <= r_bz * r_cx;
        r_p_bxcz <= r_bx * r_cz;
        r_bx2    <= r_bx;
        r_bz2    <= r_bz;
        r_b1x2   <= r_b1x;
        r_b1z2   <= r_b1z;

        r_f    <= {r_p_azbx[M-1], r_p_azbx} - {r_p_axbz[M-1], r_p_axbz};
        r_aa   <= {r_p_azcx[M-1], r_p_azcx} - {r_p_axcz[M-1], r_p_axcz};
        r_bb   <= {r_p_bzcx[M-1], r_p_bzcx} - {r_p_bxcz[M-1], r_p_bxcz};
        r_bx3  <= r_bx2;
        r_bz3  <= r_bz2;
        r_b1x3 <= r_b1x2;
        r_b1z3 <= r_b1z2;
    end

    assign o_vld = r_vld[PERP_LAT-1];
    assign o_f   = r_f;
    assign o_aa  = r_aa;
    assign o_bb  = r_bb;
    assign o_bx  = r_bx3;
    assign o_bz  = r_bz3;
    assign o_b1x = r_b1x3;
    assign o_b1z = r_b1z3;

endmodule

@@ hdl/sip_div_step.sv @@
// ----------------------------------------------------------------------------
// sip_div_step
// One restoring-division step: tries the divisor shifted by SHIFT.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sip_div_step #(
    parameter int COORD_BITS = 16,
    parameter int SHIFT      = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [3*COORD_BITS:0]   i_rem,
    input  logic [2*COORD_BITS:0]   i_den,
    input  logic [COORD_BITS-1:0]   i_quo,
    output logic                    o_vld,
    output logic [3*COORD_BITS:0]   o_rem,
    output logic [2*COORD_BITS:0]   o_den,
    output logic [COORD_BITS-1:0]   o_quo
);
    localparam int N  = 3 * COORD_BITS + 1;
    localparam int DW = 2 * COORD_BITS + 1;

    logic         r_vld;
    logic [N-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [COORD_BITS-1:0] r_quo;

    logic [N-1:0] sub_den;
    logic [N-1:0] r_den_ext;
    logic         take;
    logic [COORD_BITS-1:0] n_quo;
    logic [N-1:0] n_rem;

    always_comb begin
        sub_den = {{(N-DW){1'b0}}, i_den} << SHIFT;
        take    = (i_rem >= sub_den);
        n_rem   = take ? (i_rem - sub_den) : i_rem;
        n_quo   = i_quo;
        n_quo[SHIFT] = take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= i_den;
        r_quo <= n_quo;
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

    assign r_den_ext = {{(N-DW){1'b0}}, r_den} << SHIFT;

    // partial remainder always stays below the divisor at this weight
    `ASSERT_IMP(a_rem_bound, r_vld, r_rem < r_den_ext)
    `ASSERT_IMP(a_den_nz, r_vld, r_den != '0)
    `ASSERT_NEXT(a_vld_follow, i_vld, r_vld)

endmodule

@@ hdl/segment_intersection_point.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_point
// Crossing point of two plane segments, signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the eight endpoint coordinates and pulse start; busy is always low,
//   so a request is taken on every cycle that start is high.
//   Each request gives one result: o_valid is high for one cycle with
//   o_hit, o_cross_x and o_cross_z. A new request may enter every cycle,
//   so throughput is one result per clock.
//   Each request passes through the restoring divider, one quotient bit per stage
//   (COORD_BITS stages), behind three perp-dot stages, a range-check stage,
//   a split multiply, a partial-product add and the output register.
//   o_hit is low for parallel or degenerate pairs and for crossings outside
//   either segment; the crossing coordinates are zero then.
//   Synchronous reset empties the pipeline; requests in flight are dropped.
//   The receiver must take each result in the cycle it is shown.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_point #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_a_start_x,
    input  logic signed [COORD_BITS-1:0] i_a_start_z,
    input  logic signed [COORD_BITS-1:0] i_a_end_x,
    input  logic signed [COORD_BITS-1:0] i_a_end_z,
    input  logic signed [COORD_BITS-1:0] i_b_start_x,
    input  logic signed [COORD_BITS-1:0] i_b_start_z,
    input  logic signed [COORD_BITS-1:0] i_b_end_x,
    input  logic signed [COORD_BITS-1:0] i_b_end_z,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_cross_x,
    output logic signed [COORD_BITS-1:0] o_cross_z
);
    import sip_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int D   = W + DIFF_GROW;
    localparam int P   = 2 * D + 1;
    localparam int T   = 2 * W + 1;
    localparam int L   = W + 1;
    localparam int N   = 3 * W + 1;
    localparam int LAT = PERP_LAT + W + 4;

    // front end
    logic                pp_vld;
    logic signed [P-1:0] pp_f, pp_aa, pp_bb;
    logic signed [D-1:0] pp_bx, pp_bz;
    logic signed [W-1:0] pp_b1x, pp_b1z;

    sip_perp #(.COORD_BITS(COORD_BITS)) u_perp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (start),
        .i_a_start_x (i_a_start_x),
        .i_a_start_z (i_a_start_z),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_z   (i_a_end_z),
        .i_b_start_x (i_b_start_x),
        .i_b_start_z (i_b_start_z),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_z   (i_b_end_z),
        .o_vld       (pp_vld),
        .o_f         (pp_f),
        .o_aa        (pp_aa),
        .o_bb        (pp_bb),
        .o_bx        (pp_bx),
        .o_bz        (pp_bz),
        .o_b1x       (pp_b1x),
        .o_b1z       (pp_b1z)
    );

    // range check and magnitudes
    logic                in_rng;
    logic signed [P-1:0] t_sgn;
    logic [P-1:0]        t_abs;
    logic [P-1:0]        f_abs;
    logic [D-1:0]        bx_abs, bz_abs;

    always_comb begin
        if (pp_f[P-1]) begin
            in_rng = (pp_aa <= 0) && (pp_bb <= 0) && (pp_aa >= pp_f) && (pp_bb >= pp_f);
        end else begin
            in_rng = (pp_f != 0) && (pp_aa >= 0) && (pp_bb >= 0)
                     && (pp_aa <= pp_f) && (pp_bb <= pp_f);
        end
        t_sgn  = pp_f - pp_aa;
        t_abs  = t_sgn[P-1] ? P'(-t_sgn) : P'(t_sgn);
        f_abs  = pp_f[P-1] ? P'(-pp_f) : P'(pp_f);
        bx_abs = pp_bx[D-1] ? D'(-pp_bx) : D'(pp_bx);
        bz_abs = pp_bz[D-1] ? D'(-pp_bz) : D'(pp_bz);
    end

    logic          r4_vld, r4_ok, r4_sx, r4_sz;
    logic [T-1:0]  r4_t, r4_d;
    logic [W-1:0]  r4_bx, r4_bz;
    logic signed [W-1:0] r4_b1x, r4_b1z;

    // split multiply
    logic                r5_vld, r5_ok, r5_sx, r5_sz;
    logic [2*W:0]        r5_lo_x, r5_lo_z;
    logic [2*W-1:0]      r5_hi_x, r5_hi_z;
    logic [T-1:0]        r5_d;
    logic signed [W-1:0] r5_b1x, r5_b1z;

    // partial-product add
    logic                r6_vld, r6_ok, r6_sx, r6_sz;
    logic [N-1:0]        r6_nx, r6_nz;
    logic [T-1:0]        r6_d;
    logic signed [W-1:0] r6_b1x, r6_b1z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r4_vld <= pp_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // a miss runs through as 0 / 1 so the divider stays well formed
        r4_ok  <= in_rng;
        r4_t   <= in_rng ? t_abs[T-1:0] : '0;
        r4_d   <= in_rng ? f_abs[T-1:0] : T'(1);
        r4_bx  <= bx_abs[W-1:0];
        r4_bz  <= bz_abs[W-1:0];
        r4_sx  <= pp_bx[D-1];
        r4_sz  <= pp_bz[D-1];
        r4_b1x <= pp_b1x;
        r4_b1z <= pp_b1z;

        r5_lo_x <= r4_bx * r4_t[L-1:0];
        r5_hi_x <= r4_bx * r4_t[T-1:L];
        r5_lo_z <= r4_bz * r4_t[L-1:0];
        r5_hi_z <= r4_bz * r4_t[T-1:L];
        r5_ok   <= r4_ok;
        r5_sx   <= r4_sx;
        r5_sz   <= r4_sz;
        r5_d    <= r4_d;
        r5_b1x  <= r4_b1x;
        r5_b1z  <= r4_b1z;

        r6_nx  <= N'(r5_lo_x) + (N'(r5_hi_x) << L);
        r6_nz  <= N'(r5_lo_z) + (N'(r5_hi_z) << L);
        r6_ok  <= r5_ok;
        r6_sx  <= r5_sx;
        r6_sz  <= r5_sz;
        r6_d   <= r5_d;
        r6_b1x <= r5_b1x;
        r6_b1z <= r5_b1z;
    end

    // divider chains, quotient msb first
    logic         dx_vld [0:W];
    logic [N-1:0] dx_rem [0:W];
    logic [T-1:0] dx_den [0:W];
    logic [W-1:0] dx_quo [0:W];
    logic         dz_vld [0:W];
    logic [N-1:0] dz_rem [0:W];
    logic [T-1:0] dz_den [0:W];
    logic [W-1:0] dz_quo [0:W];

    assign dx_vld[0] = r6_vld;
    assign dx_rem[0] = r6_nx;
    assign dx_den[0] = r6_d;
    assign dx_quo[0] = '0;
    assign dz_vld[0] = r6_vld;
    assign dz_rem[0] = r6_nz;
    assign dz_den[0] = r6_d;
    assign dz_quo[0] = '0;

    for (genvar k = 0; k < W; k++) begin : g_div
        sip_div_step #(.COORD_BITS(COORD_BITS), .SHIFT(W-1-k)) u_dx (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (dx_vld[k]),
            .i_rem   (dx_rem[k]),
            .i_den   (dx_den[k]),
            .i_quo   (dx_quo[k]),
            .o_vld   (dx_vld[k+1]),
            .o_rem   (dx_rem[k+1]),
            .o_den   (dx_den[k+1]),
            .o_quo   (dx_quo[k+1])
        );
        sip_div_step #(.COORD_BITS(COORD_BITS), .SHIFT(W-1-k)) u_dz (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (dz_vld[k]),
            .i_rem   (dz_rem[k]),
            .i_den   (dz_den[k]),
            .i_quo   (dz_quo[k]),
            .o_vld   (dz_vld[k+1]),
            .o_rem   (dz_rem[k+1]),
            .o_den   (dz_den[k+1]),
            .o_quo   (dz_quo[k+1])
        );
    end

    // side data travelling alongside the divider
    logic                r_sd_ok  [0:W-1];
    logic                r_sd_sx  [0:W-1];
    logic                r_sd_sz  [0:W-1];
    logic signed [W-1:0] r_sd_b1x [0:W-1];
    logic signed [W-1:0] r_sd_b1z [0:W-1];

    always_ff @(posedge i_clk) begin
        r_sd_ok[0]  <= r6_ok;
        r_sd_sx[0]  <= r6_sx;
        r_sd_sz[0]  <= r6_sz;
        r_sd_b1x[0] <= r6_b1x;
        r_sd_b1z[0] <= r6_b1z;
        for (int i = 1; i < W; i++) begin
            r_sd_ok[i]  <= r_sd_ok[i-1];
            r_sd_sx[i]  <= r_sd_sx[i-1];
            r_sd_sz[i]  <= r_sd_sz[i-1];
            r_sd_b1x[i] <= r_sd_b1x[i-1];
            r_sd_b1z[i] <= r_sd_b1z[i-1];
        end
    end

    // signed quotient plus start point, wrapped to the coordinate width
    logic [W-1:0] qx, qz;
    logic [W-1:0] n_cross_x, n_cross_z;

    always_comb begin
        qx = r_sd_sx[W-1] ? W'(-dx_quo[W]) : dx_quo[W];
        qz = r_sd_sz[W-1] ? W'(-dz_quo[W]) : dz_quo[W];
        n_cross_x = r_sd_ok[W-1] ? W'(r_sd_b1x[W-1] + qx) : '0;
        n_cross_z = r_sd_ok[W-1] ? W'(r_sd_b1z[W-1] + qz) : '0;
    end

    logic         r_valid, r_hit;
    logic [W-1:0] r_cross_x, r_cross_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= dx_vld[W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit     <= r_sd_ok[W-1];
        r_cross_x <= n_cross_x;
        r_cross_z <= n_cross_z;
    end

    assign busy      = 1'b0;
    assign o_valid   = r_valid;
    assign o_hit     = r_hit;
    assign o_cross_x = r_cross_x;
    assign o_cross_z = r_cross_z;

    `ASSERT_IMP(a_lat, start, ##LAT o_valid)
    `ASSERT_IMP(a_src, o_valid, $past(start, LAT))
    `ASSERT_IMP(a_miss_zero, o_valid && !o_hit, o_cross_x == 0 && o_cross_z == 0)
    `ASSERT_IMP(a_chain_sync, dx_vld[W] || dz_vld[W], dx_vld[W] && dz_vld[W])

endmodule
